[rtl/vsc_pkg.sv]
`default_nettype none

package vsc_pkg;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  // verdict codes
  localparam logic [1:0] VERDICT_KEEP    = 2'd0;
  localparam logic [1:0] VERDICT_OUT_IMG = 2'd1;
  localparam logic [1:0] VERDICT_OUT_SIL = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_ROT0  = 3'd0;
  localparam logic [2:0] REG_ROT1  = 3'd1;
  localparam logic [2:0] REG_ROT2  = 3'd2;
  localparam logic [2:0] REG_TRANS = 3'd3;
  localparam logic [2:0] REG_FOCAL = 3'd4;
  localparam logic [2:0] REG_COLS  = 3'd5;
  localparam logic [2:0] REG_ROWS  = 3'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;
  localparam int ROT_W      = 18;
  localparam int TRANS_W    = 20;

  typedef struct packed {
    logic        command;
    logic [19:0] pixel_address;
    logic        pixel_inside;
    logic signed [23:0] voxel_x;
    logic signed [23:0] voxel_y;
    logic signed [23:0] voxel_z;
    logic [23:0] voxel_index;
  } item_t;

  typedef struct packed {
    logic [23:0] result_index;
    logic [1:0]  verdict;
  } result_t;

  // sideband that travels down the pipeline with every word
  typedef struct packed {
    logic        command;
    logic        pixel_inside;
    logic [19:0] pixel_address;
    logic [23:0] voxel_index;
    logic        oor;
  } carry_t;

endpackage

`default_nettype wire

[rtl/voxel_silhouette_carve.sv]
`default_nettype none

// Channel   Direction  Handshake            Word
// item      in         item_valid/stall     vsc_pkg::item_t (load or test)
// result    out        result_valid/stall   vsc_pkg::result_t (one per test)
// cfg       in         cfg_valid/ready      cfg_index, cfg_data
//
// One word per cycle is taken while item_stall is low, loads and tests mixed.
// The depth a test word passes before its result shows is set by the restoring
// divider, one quotient bit per stage. Loads write the silhouette memory in the
// same stage where tests read it, so accesses stay in order. Reset restores
// control and configuration; the memory is not cleared. A stalled result fills
// a skid register, which stalls the item side.

module voxel_silhouette_carve #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire vsc_pkg::item_t                item,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output vsc_pkg::result_t                   result,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [vsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vsc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int MAXD        = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int DQ          = $clog2(MAXD);
  localparam int LIM_W       = $clog2(MAXD + 1);
  localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int OOR_IDX     = 6;
  localparam int A_IDX       = 7 + DQ;
  localparam int M_IDX       = 8 + DQ;
  localparam int NST         = 9 + DQ;
  localparam int NW          = 57;
  localparam int DW          = 38;
  localparam int PW          = LIM_W + DW;

  // configuration registers
  logic [53:0] rot [3];
  logic [59:0] trans;
  logic [23:0] focal;
  logic [10:0] cols;
  logic [10:0] rows;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot[0] <= '0;
      rot[1] <= '0;
      rot[2] <= '0;
      trans  <= '0;
      focal  <= '0;
      cols   <= 11'd1024;
      rows   <= 11'd1024;
    end else if (cfg_valid) begin
      case (cfg_index)
        vsc_pkg::REG_ROT0:  rot[0] <= cfg_data[53:0];
        vsc_pkg::REG_ROT1:  rot[1] <= cfg_data[53:0];
        vsc_pkg::REG_ROT2:  rot[2] <= cfg_data[53:0];
        vsc_pkg::REG_TRANS: trans  <= cfg_data[59:0];
        vsc_pkg::REG_FOCAL: focal  <= cfg_data[23:0];
        vsc_pkg::REG_COLS:  cols   <= cfg_data[10:0];
        vsc_pkg::REG_ROWS:  rows   <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // image constants derived from registers
  logic [10:0]      rows1;
  logic [9:0]       ctrx;
  logic [9:0]       yoff;
  logic [LIM_W-1:0] lim_c;
  logic [LIM_W-1:0] lim_r;

  always_comb begin
    rows1 = (rows == 11'd0) ? 11'd0 : rows - 11'd1;
    ctrx  = (cols == 11'd0) ? 10'd0 : 10'((cols - 11'd1) >> 1);
    yoff  = 10'(rows1 - (rows1 >> 1));
    lim_c = (32'(cols) < MAX_COLS) ? LIM_W'(cols) : LIM_W'(MAX_COLS);
    lim_r = (32'(rows) < MAX_ROWS) ? LIM_W'(rows) : LIM_W'(MAX_ROWS);
  end

  // output and skid registers
  vsc_pkg::result_t skid;
  logic             skid_valid;
  logic             adv;

  assign adv        = !skid_valid;
  assign item_stall = skid_valid;

  // pipeline valid bits and sideband
  logic              vld [NST];
  vsc_pkg::carry_t   sb  [NST];
  vsc_pkg::carry_t   sb_mark;
  logic              oor_now;

  always_comb begin
    sb_mark     = sb[OOR_IDX-1];
    sb_mark.oor = oor_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NST; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= item_valid;
      for (int k = 1; k < NST; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb[0].command       <= item.command;
      sb[0].pixel_inside  <= item.pixel_inside;
      sb[0].pixel_address <= item.pixel_address;
      sb[0].voxel_index   <= item.voxel_index;
      sb[0].oor           <= 1'b0;
      for (int k = 1; k < NST; k++) begin
        if (k == OOR_IDX) begin
          sb[k] <= sb_mark;
        end else begin
          sb[k] <= sb[k-1];
        end
      end
    end
  end

  // stage 0: voxel point
  logic signed [23:0] pt [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      pt[0] <= item.voxel_x;
      pt[1] <= item.voxel_y;
      pt[2] <= item.voxel_z;
    end
  end

  // stage 1: rotation products
  logic signed [41:0] pr [3][3];
  logic signed [19:0] tr [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        tr[i] <= $signed(trans[vsc_pkg::TRANS_W*i +: vsc_pkg::TRANS_W]);
        for (int j = 0; j < 3; j++) begin
          pr[i][j] <= $signed(rot[i][vsc_pkg::ROT_W*j +: vsc_pkg::ROT_W]) * pt[j];
        end
      end
    end
  end

  // stage 2: camera coordinates, floored to Q.8
  logic [44:0]        acc [3];
  logic signed [28:0] cc  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = {{9{tr[i][19]}}, tr[i], 16'b0} + 45'(pr[i][0]) + 45'(pr[i][1])
             + 45'(pr[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        cc[i] <= $signed(acc[i][44:16]);
      end
    end
  end

  // stage 3: projection products
  logic signed [36:0] den;
  logic signed [47:0] mx3;
  logic signed [47:0] my3;
  logic signed [53:0] fx3;
  logic signed [53:0] fy3;
  logic signed [36:0] den3;
  logic               zero3;

  assign den = $signed({cc[2], 8'b0});

  always_ff @(posedge clk) begin
    if (adv) begin
      mx3   <= $signed({1'b0, ctrx}) * den;
      my3   <= $signed({1'b0, yoff}) * den;
      fx3   <= $signed({1'b0, focal}) * cc[0];
      fy3   <= $signed({1'b0, focal}) * cc[1];
      den3  <= den;
      zero3 <= (cc[2] == 29'sd0);
    end
  end

  // stage 4: numerators, positive denominator
  logic signed [55:0] nx_raw;
  logic signed [55:0] ny_raw;
  logic signed [55:0] nx4;
  logic signed [55:0] ny4;
  logic [36:0]        d4;
  logic               zero4;

  always_comb begin
    nx_raw = 56'(mx3) - 56'(fx3);
    ny_raw = 56'(my3) + 56'(fy3);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nx4   <= den3[36] ? -nx_raw : nx_raw;
      ny4   <= den3[36] ? -ny_raw : ny_raw;
      d4    <= den3[36] ? 37'(-den3) : 37'(den3);
      zero4 <= zero3;
    end
  end

  // stage 5: rounding numerators and range limits
  logic [55:0]      magx;
  logic [55:0]      magy;
  logic [DW-1:0]    dd2;
  logic [LIM_W-1:0] limx;
  logic [LIM_W-1:0] limy;
  logic [NW-1:0]    nx5;
  logic [NW-1:0]    ny5;
  logic [DW-1:0]    d5;
  logic [PW-1:0]    lx5;
  logic [PW-1:0]    ly5;
  logic             zero5;

  always_comb begin
    magx = nx4[55] ? 56'(-nx4) : 56'(nx4);
    magy = ny4[55] ? 56'(-ny4) : 56'(ny4);
    dd2  = {d4, 1'b0};
    // a negative numerator only survives when it rounds to zero
    limx = nx4[55] ? LIM_W'(lim_c != '0) : lim_c;
    limy = ny4[55] ? LIM_W'(lim_r != '0) : lim_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nx5   <= {magx, 1'b0} + NW'(d4);
      ny5   <= {magy, 1'b0} + NW'(d4);
      d5    <= dd2;
      lx5   <= PW'(limx) * PW'(dd2);
      ly5   <= PW'(limy) * PW'(dd2);
      zero5 <= zero4;
    end
  end

  assign oor_now = zero5 || !(NW'(nx5) < NW'(lx5)) || !(NW'(ny5) < NW'(ly5));

  // stage 6 and on: restoring division, one quotient bit per stage
  logic [NW-1:0] rx [DQ+1];
  logic [NW-1:0] ry [DQ+1];
  logic [DW-1:0] dv [DQ+1];
  logic [DQ-1:0] qx [DQ+1];
  logic [DQ-1:0] qy [DQ+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      rx[0] <= nx5;
      ry[0] <= ny5;
      dv[0] <= d5;
      qx[0] <= '0;
      qy[0] <= '0;
    end
  end

  for (genvar k = 0; k < DQ; k++) begin : g_div
    localparam int B = DQ - 1 - k;
    logic [NW-1:0] sub;
    logic          gex;
    logic          gey;
    logic [DQ-1:0] qxn;
    logic [DQ-1:0] qyn;

    always_comb begin
      sub    = NW'(dv[k]) << B;
      gex    = (rx[k] >= sub);
      gey    = (ry[k] >= sub);
      qxn    = qx[k];
      qyn    = qy[k];
      qxn[B] = gex;
      qyn[B] = gey;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rx[k+1] <= gex ? rx[k] - sub : rx[k];
        ry[k+1] <= gey ? ry[k] - sub : ry[k];
        dv[k+1] <= dv[k];
        qx[k+1] <= qxn;
        qy[k+1] <= qyn;
      end
    end
  end

  // address stage
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          wok;

  always_ff @(posedge clk) begin
    if (adv) begin
      raddr <= AW'(32'(qy[DQ]) * 32'(MAX_COLS) + 32'(qx[DQ]));
      waddr <= AW'(sb[A_IDX-1].pixel_address);
      wok   <= (32'(sb[A_IDX-1].pixel_address) < STORE_DEPTH);
    end
  end

  // silhouette memory: loads and tests meet here in order
  logic mem [STORE_DEPTH];
  logic rd_bit;

  always_ff @(posedge clk) begin
    if (adv && vld[A_IDX]) begin
      if (sb[A_IDX].command == vsc_pkg::CMD_LOAD) begin
        if (wok) begin
          mem[waddr] <= sb[A_IDX].pixel_inside;
        end
      end else if (!sb[A_IDX].oor) begin
        rd_bit <= mem[raddr];
      end
    end
  end

  // verdict and output
  vsc_pkg::result_t res_new;
  logic             push;
  logic             take;

  always_comb begin
    res_new.result_index = sb[M_IDX].voxel_index;
    if (sb[M_IDX].oor) begin
      res_new.verdict = vsc_pkg::VERDICT_OUT_IMG;
    end else if (rd_bit) begin
      res_new.verdict = vsc_pkg::VERDICT_KEEP;
    end else begin
      res_new.verdict = vsc_pkg::VERDICT_OUT_SIL;
    end
    push = adv && vld[M_IDX] && (sb[M_IDX].command == vsc_pkg::CMD_TEST);
    take = result_valid && !result_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (push) begin
      if (!result_valid || take) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!result_valid || take) begin
        result <= res_new;
      end else begin
        skid <= res_new;
      end
    end else if (take && skid_valid) begin
      result <= skid;
    end
  end

endmodule

`default_nettype wire

[rtl/vsc_check.sv]
`default_nettype none

module vsc_check (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_stall,
  input wire logic             result_valid,
  input wire logic             result_stall,
  input wire vsc_pkg::result_t result,
  input wire logic             cfg_valid,
  input wire logic             cfg_ready
);

  // a stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // the item side only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> $past(result_valid && result_stall))
    else $error("item stall without a stalled result");

  // reset empties both sides
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("words left after reset");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.verdict == vsc_pkg::VERDICT_KEEP ||
                      result.verdict == vsc_pkg::VERDICT_OUT_IMG ||
                      result.verdict == vsc_pkg::VERDICT_OUT_SIL))
    else $error("verdict code out of range");

  // configuration writes are never held off
  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind voxel_silhouette_carve vsc_check u_vsc_check (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);

`default_nettype wire
